// ===== src/idw_pkg.sv =====
// Shared types and constants for the I2C display byte writer.
package idw_pkg;

  localparam int unsigned PHASE_W       = 7;
  localparam int unsigned TOTAL_PHASES  = 89;
  localparam int unsigned START_PHASES  = 4;
  localparam int unsigned SEG_PHASES    = 27;
  localparam int unsigned BYTE_PHASES   = 25;
  localparam int unsigned STOP_BASE     = START_PHASES + 3 * SEG_PHASES;

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(TOTAL_PHASES - 1);

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  localparam logic [1:0] SEG_ADDR = 2'd0;
  localparam logic [1:0] SEG_CTRL = 2'd1;
  localparam logic [1:0] SEG_LOAD = 2'd2;

  localparam logic [7:0] ADDR_RESET = 8'h78;
  localparam logic [7:0] CTRL_CMD   = 8'h00;
  localparam logic [7:0] CTRL_DATA  = 8'h40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic rejected;
  } out_item_t;

  typedef struct packed {
    logic       scl_we;
    logic       scl_val;
    logic       sda_we;
    logic       sda_from_byte;
    logic       sda_val;
    logic [1:0] seg;
    logic [2:0] bit_sel;
  } action_t;

endpackage

// ===== src/idw_phase_dec.sv =====
// Pin action decode for one phase index of the transfer.
module idw_phase_dec (
  input  logic [idw_pkg::PHASE_W-1:0] phase_i,
  output idw_pkg::action_t            action_o
);

  logic [idw_pkg::PHASE_W-1:0] q;
  logic [idw_pkg::PHASE_W-1:0] r_full;
  logic [4:0]                  r;
  logic [4:0]                  x;
  logic [8:0]                  prod;
  logic [2:0]                  bit_idx;
  logic [4:0]                  step;
  logic [1:0]                  seg;
  logic [idw_pkg::PHASE_W-1:0] sp;

  always_comb begin
    q = phase_i - idw_pkg::PHASE_W'(idw_pkg::START_PHASES);
    if (q >= idw_pkg::PHASE_W'(2 * idw_pkg::SEG_PHASES)) begin
      seg    = idw_pkg::SEG_LOAD;
      r_full = q - idw_pkg::PHASE_W'(2 * idw_pkg::SEG_PHASES);
    end else if (q >= idw_pkg::PHASE_W'(idw_pkg::SEG_PHASES)) begin
      seg    = idw_pkg::SEG_CTRL;
      r_full = q - idw_pkg::PHASE_W'(idw_pkg::SEG_PHASES);
    end else begin
      seg    = idw_pkg::SEG_ADDR;
      r_full = q;
    end
    r       = r_full[4:0];
    x       = r - 5'd1;
    // x / 3 for x below 24
    prod    = 9'(x) * 9'd11;
    bit_idx = prod[7:5];
    step    = x - 5'(bit_idx) * 5'd3;
    sp      = phase_i - idw_pkg::PHASE_W'(idw_pkg::STOP_BASE);

    action_o               = '0;
    action_o.seg           = seg;
    action_o.bit_sel       = 3'd7 - bit_idx;

    if (phase_i < idw_pkg::PHASE_W'(idw_pkg::START_PHASES)) begin
      unique case (phase_i[1:0])
        2'd0: begin action_o.sda_we = 1'b1; action_o.sda_val = 1'b1; end
        2'd1: begin action_o.scl_we = 1'b1; action_o.scl_val = 1'b1; end
        2'd2: begin action_o.sda_we = 1'b1; action_o.sda_val = 1'b0; end
        default: begin action_o.scl_we = 1'b1; action_o.scl_val = 1'b0; end
      endcase
    end else if (phase_i < idw_pkg::PHASE_W'(idw_pkg::STOP_BASE)) begin
      if (r == 5'd0) begin
        action_o.scl_we = 1'b1;
        action_o.scl_val = 1'b0;
      end else if (r < 5'(idw_pkg::BYTE_PHASES)) begin
        priority if (step == 5'd0) begin
          action_o.sda_we        = 1'b1;
          action_o.sda_from_byte = 1'b1;
        end else if (step == 5'd1) begin
          action_o.scl_we  = 1'b1;
          action_o.scl_val = 1'b1;
        end else begin
          action_o.scl_we  = 1'b1;
          action_o.scl_val = 1'b0;
        end
      end else if (r == 5'(idw_pkg::BYTE_PHASES)) begin
        action_o.scl_we  = 1'b1;
        action_o.scl_val = 1'b1;
      end else begin
        action_o.scl_we  = 1'b1;
        action_o.scl_val = 1'b0;
      end
    end else if (phase_i < idw_pkg::PHASE_W'(idw_pkg::TOTAL_PHASES)) begin
      unique case (sp[1:0])
        2'd0: begin action_o.scl_we = 1'b1; action_o.scl_val = 1'b0; end
        2'd1: begin action_o.sda_we = 1'b1; action_o.sda_val = 1'b0; end
        2'd2: begin action_o.scl_we = 1'b1; action_o.scl_val = 1'b1; end
        default: begin action_o.sda_we = 1'b1; action_o.sda_val = 1'b1; end
      endcase
    end
  end

endmodule

// ===== src/idw_core.sv =====
// Transfer state, pin registers and per-item update.
module idw_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  idw_pkg::in_item_t   item_i,
  input  logic [7:0]          dev_addr_i,
  output idw_pkg::out_item_t  result_o
);

  logic [idw_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [7:0]                  payload_q, payload_d;
  logic                        is_data_q, is_data_d;
  logic                        active_q, active_d;
  logic                        scl_q, scl_d;
  logic                        sda_q, sda_d;
  logic                        rej;
  logic [7:0]                  seg_byte;
  idw_pkg::action_t            act;

  idw_phase_dec u_dec (
    .phase_i  (phase_q),
    .action_o (act)
  );

  always_comb begin
    unique case (act.seg)
      idw_pkg::SEG_ADDR: seg_byte = dev_addr_i;
      idw_pkg::SEG_CTRL: seg_byte = is_data_q ? idw_pkg::CTRL_DATA : idw_pkg::CTRL_CMD;
      default:           seg_byte = payload_q;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    payload_d = payload_q;
    is_data_d = is_data_q;
    active_d  = active_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    rej       = 1'b0;
    unique case (item_i.kind)
      idw_pkg::KIND_TICK: begin
        if (active_q) begin
          if (act.scl_we) scl_d = act.scl_val;
          if (act.sda_we) sda_d = act.sda_from_byte ? seg_byte[act.bit_sel] : act.sda_val;
          if (phase_q >= idw_pkg::LAST_PHASE) begin
            active_d = 1'b0;
            phase_d  = '0;
          end else begin
            phase_d = phase_q + idw_pkg::PHASE_W'(1);
          end
        end
      end
      idw_pkg::KIND_CMD, idw_pkg::KIND_DATA: begin
        if (active_q) begin
          rej = 1'b1;
        end else begin
          payload_d = item_i.payload;
          is_data_d = (item_i.kind == idw_pkg::KIND_DATA);
          phase_d   = '0;
          active_d  = 1'b1;
        end
      end
      default: ;
    endcase
    result_o.scl_level = scl_d;
    result_o.sda_level = sda_d;
    result_o.busy_res  = active_d;
    result_o.rejected  = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      payload_q <= '0;
      is_data_q <= 1'b0;
      active_q  <= 1'b0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      payload_q <= payload_d;
      is_data_q <= is_data_d;
      active_q  <= active_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

endmodule

// ===== src/i2c_display_byte_writer.sv =====
// Top level of the write-only I2C display byte writer.
// Input channel (in_valid_i/in_ready_o/in_data_i): one item is a tick (kind 0),
// a command request (kind 1) or a data request (kind 2). A request loads the
// byte; each later tick applies one SCL/SDA phase of the 89-phase transfer.
// Output channel (out_valid_o/out_ready_i/out_data_o): one item per input item
// with the pin levels, busy flag and a flag for a request dropped while busy.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): device address byte,
// write bit included; always ready, write it only while idle.
// The result is registered and presented the cycle after the input item is taken.
// Throughput: one item per cycle unless the output stalls; the bus rate follows the tick rate.
// The single output register lets a new item in whenever it is empty or
// being taken in the same cycle; a stalled receiver holds the result and
// blocks input after one item.
// Reset: bus idle (SCL and SDA high), no transfer, address byte 0x78,
// output empty.
module i2c_display_byte_writer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  idw_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output idw_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  logic               cfg_we;
  logic [7:0]         dev_addr_q;
  logic               out_valid_q, out_valid_d;
  idw_pkg::out_item_t out_q;
  idw_pkg::out_item_t result;
  logic               accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  idw_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .dev_addr_i (dev_addr_q),
    .result_o   (result)
  );

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= idw_pkg::ADDR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) dev_addr_q <= cfg_data_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== dv/tb_i2c_display_byte_writer.sv =====
// Testbench for the I2C display byte writer: random items against a pin-level predictor.
module tb_i2c_display_byte_writer;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int unsigned ITEMS_PER_SETTING = 300;

  class pin_scoreboard;
    logic [7:0]          addr_byte;
    int unsigned         phase_no;
    logic [7:0]          held_byte;
    logic                is_data;
    logic                active;
    logic                scl;
    logic                sda;
    idw_pkg::out_item_t  pin_levels_q[$];
    int                  errors;

    function new();
      addr_byte = idw_pkg::ADDR_RESET;
      phase_no  = 0;
      held_byte = 8'h00;
      is_data   = 1'b0;
      active    = 1'b0;
      scl       = 1'b1;
      sda       = 1'b1;
      errors    = 0;
    endfunction

    function void set_address(logic [7:0] value);
      addr_byte = value;
    endfunction

    function int pending();
      return pin_levels_q.size();
    endfunction

    function void apply_phase(int unsigned p);
      int unsigned q;
      int unsigned seg;
      int unsigned r;
      int unsigned bit_no;
      int unsigned sub;
      logic [7:0]  line_byte;
      if (p < idw_pkg::START_PHASES) begin
        case (p)
          0: sda = 1'b1;
          1: scl = 1'b1;
          2: sda = 1'b0;
          default: scl = 1'b0;
        endcase
      end else if (p < idw_pkg::STOP_BASE) begin
        q   = p - idw_pkg::START_PHASES;
        seg = q / idw_pkg::SEG_PHASES;
        r   = q % idw_pkg::SEG_PHASES;
        if (r == 0) begin
          scl = 1'b0;
        end else if (r < idw_pkg::BYTE_PHASES) begin
          bit_no = (r - 1) / 3;
          sub    = (r - 1) % 3;
          if (sub == 0) begin
            if (seg == idw_pkg::SEG_ADDR) line_byte = addr_byte;
            else if (seg == idw_pkg::SEG_CTRL)
              line_byte = is_data ? idw_pkg::CTRL_DATA : idw_pkg::CTRL_CMD;
            else line_byte = held_byte;
            sda = line_byte[7 - bit_no];
          end else begin
            scl = (sub == 1);
          end
        end else begin
          scl = (r == idw_pkg::BYTE_PHASES);
        end
      end else begin
        case (p - idw_pkg::STOP_BASE)
          0: scl = 1'b0;
          1: sda = 1'b0;
          2: scl = 1'b1;
          default: sda = 1'b1;
        endcase
      end
    endfunction

    function void note_input(idw_pkg::in_item_t it);
      idw_pkg::out_item_t e;
      logic               rej;
      rej = 1'b0;
      case (it.kind)
        idw_pkg::KIND_TICK: begin
          if (active) begin
            if (phase_no < idw_pkg::TOTAL_PHASES) begin
              apply_phase(phase_no);
              phase_no++;
            end
            if (phase_no >= idw_pkg::TOTAL_PHASES) begin
              active   = 1'b0;
              phase_no = 0;
            end
          end
        end
        idw_pkg::KIND_CMD, idw_pkg::KIND_DATA: begin
          if (active) begin
            rej = 1'b1;
          end else begin
            held_byte = it.payload;
            is_data   = (it.kind == idw_pkg::KIND_DATA);
            phase_no  = 0;
            active    = 1'b1;
          end
        end
        default: ;
      endcase
      e.scl_level = scl;
      e.sda_level = sda;
      e.busy_res  = active;
      e.rejected  = rej;
      pin_levels_q.push_back(e);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(idw_pkg::out_item_t got);
      idw_pkg::out_item_t e;
      if (pin_levels_q.size() == 0) begin
        report($sformatf("result %b with nothing expected", got));
        return;
      end
      e = pin_levels_q.pop_front();
      if (got.scl_level !== e.scl_level)
        report($sformatf("scl_level %b, expected %b", got.scl_level, e.scl_level));
      if (got.sda_level !== e.sda_level)
        report($sformatf("sda_level %b, expected %b", got.sda_level, e.sda_level));
      if (got.busy_res !== e.busy_res)
        report($sformatf("busy_res %b, expected %b", got.busy_res, e.busy_res));
      if (got.rejected !== e.rejected)
        report($sformatf("rejected %b, expected %b", got.rejected, e.rejected));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  idw_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  idw_pkg::out_item_t out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [7:0]         cfg_data_i;

  pin_scoreboard sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            items_sent;

  i2c_display_byte_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic idw_pkg::in_item_t mk_item(logic [1:0] kind, logic [7:0] payload);
    idw_pkg::in_item_t it;
    it.kind    = kind;
    it.payload = payload;
    return it;
  endfunction

  task automatic push_item(idw_pkg::in_item_t it);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_address(logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_address(value);
  endtask

  task automatic tick_to_end();
    while (sb.active) push_item(mk_item(idw_pkg::KIND_TICK, 8'($urandom_range(255))));
  endtask

  task automatic run_transfer();
    int r;
    repeat ($urandom_range(2)) begin
      push_item(mk_item($urandom_range(1) ? KIND_NONE : idw_pkg::KIND_TICK,
                        8'($urandom_range(255))));
    end
    push_item(mk_item($urandom_range(1) ? idw_pkg::KIND_DATA : idw_pkg::KIND_CMD,
                      8'($urandom_range(255))));
    while (sb.active) begin
      r = $urandom_range(99);
      if (r < 90)
        push_item(mk_item(idw_pkg::KIND_TICK, 8'($urandom_range(255))));
      else if (r < 96)
        push_item(mk_item($urandom_range(1) ? idw_pkg::KIND_DATA : idw_pkg::KIND_CMD,
                          8'($urandom_range(255))));
      else
        push_item(mk_item(KIND_NONE, 8'($urandom_range(255))));
    end
  endtask

  initial begin
    #2_000_000;
    $display("tb_i2c_display_byte_writer: FAIL");
    $finish;
  end

  initial begin
    int start_count;
    int n_transfers;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 8'h00;
    send_idle_pct = 20;
    recv_idle_pct = 59;
    items_sent    = 0;
    n_transfers   = 0;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(mk_item(idw_pkg::KIND_TICK, 8'hFF));
    push_item(mk_item(KIND_NONE, 8'hAA));
    push_item(mk_item(idw_pkg::KIND_TICK, 8'h00));
    push_item(mk_item(idw_pkg::KIND_CMD, 8'h00));
    repeat (3) push_item(mk_item(idw_pkg::KIND_TICK, 8'h55));
    push_item(mk_item(idw_pkg::KIND_CMD, 8'hFF));
    push_item(mk_item(idw_pkg::KIND_DATA, 8'h5A));
    push_item(mk_item(KIND_NONE, 8'h00));
    tick_to_end();
    push_item(mk_item(idw_pkg::KIND_TICK, 8'h00));
    wait_idle();
    write_address(8'h00);
    push_item(mk_item(idw_pkg::KIND_DATA, 8'hFF));
    tick_to_end();
    wait_idle();
    write_address(8'hFF);
    push_item(mk_item(idw_pkg::KIND_CMD, 8'h80));
    tick_to_end();
    push_item(mk_item(idw_pkg::KIND_DATA, 8'h01));
    tick_to_end();

    for (int setting = 0; setting < 3; setting++) begin
      wait_idle();
      case (setting)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 59;
          write_address(8'($urandom_range(255)));
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 20;
          write_address(8'hFF);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_address(8'($urandom_range(255)));
        end
      endcase
      start_count = items_sent;
      while (items_sent - start_count < ITEMS_PER_SETTING) begin
        run_transfer();
        n_transfers++;
        if (n_transfers % 4 == 0) begin
          wait_idle();
          write_address(8'($urandom_range(255)));
        end
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_i2c_display_byte_writer: PASS");
    end else begin
      $display("tb_i2c_display_byte_writer: FAIL");
    end
    $finish;
  end

endmodule

// ===== i2c_display_byte_writer.f =====
src/idw_pkg.sv
src/idw_phase_dec.sv
src/idw_core.sv
src/i2c_display_byte_writer.sv
dv/tb_i2c_display_byte_writer.sv
